// ----- hdl/ftpp_pkg.sv -----
// ============================================================================
// ftpp_pkg
// Shared types and constants for the file transfer packet parser.
// ============================================================================
package ftpp_pkg;

    // Packets longer than this are discarded as a failed link read.
    localparam int unsigned MAX_PACKET = 1024;
    localparam int unsigned IDX_W      = 16;
    localparam int unsigned LEN_W      = IDX_W + 1;
    localparam int unsigned SIZE_W     = 64;

    localparam logic [7:0] TYPE_DATA = 8'd2;
    localparam logic [7:0] TYPE_END  = 8'd3;

    typedef enum logic [1:0] {
        PH_AWAIT = 2'd0,
        PH_XFER  = 2'd1,
        PH_DONE  = 2'd2,
        PH_FAIL  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_START_OK   = 3'd0,
        ST_DATA_OK    = 3'd1,
        ST_END_SEEN   = 3'd2,
        ST_IGNORED    = 3'd3,
        ST_START_REJ  = 3'd4,
        ST_AFTER_STOP = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_NAME    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        kind_t              byte_kind;
        logic [7:0]         out_byte;
        logic               packet_end;
        status_t            packet_status;
        logic [SIZE_W-1:0]  file_size;
        logic [7:0]         name_length;
        phase_t             phase;
    } result_t;

endpackage

// ----- hdl/ftpp_in_reg.sv -----
// ============================================================================
// ftpp_in_reg
// Input register: holds one accepted word until the parse stage takes it.
// ============================================================================
module ftpp_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_in_byte,
    input  logic           s_last,
    input  logic           take,
    output logic           item_valid,
    output ftpp_pkg::item_t item
);
    import ftpp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  s_fire;

    // The slot may refill in the same cycle that the parse stage empties it.
    assign s_ready    = !valid_reg || take;
    assign s_fire     = s_valid && s_ready;
    assign valid_next = s_fire ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.data <= s_in_byte;
            item_reg.last <= s_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hdl/ftpp_step.sv -----
// ============================================================================
// ftpp_step
// Parse state and the single-pass field logic applied to one word.
// ============================================================================
module ftpp_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  ftpp_pkg::item_t   item,
    output ftpp_pkg::result_t res
);
    import ftpp_pkg::*;

    phase_t            phase_reg,      phase_next;
    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [7:0]        packet_type_reg, packet_type_next;
    logic [7:0]        size_len_reg,   size_len_next;
    logic [SIZE_W-1:0] size_accum_reg, size_accum_next;
    logic [7:0]        name_len_reg,   name_len_next;
    logic [15:0]       data_len_reg,   data_len_next;

    logic [LEN_W-1:0]  idx_w;
    logic [LEN_W-1:0]  len_w;
    logic [LEN_W-1:0]  l_old_w;
    logic [LEN_W-1:0]  n_old_w;
    logic [LEN_W-1:0]  l_new_w;
    logic [LEN_W-1:0]  n_new_w;
    logic [LEN_W-1:0]  d_new_w;
    logic              too_long;
    kind_t             kind;
    logic [7:0]        ob;
    status_t           status;

    always_comb begin
        idx_w   = {1'b0, byte_index_reg};
        len_w   = idx_w + LEN_W'(1);
        l_old_w = LEN_W'(size_len_reg);
        n_old_w = LEN_W'(name_len_reg);

        phase_next       = phase_reg;
        packet_type_next = (byte_index_reg == '0) ? item.data : packet_type_reg;
        size_len_next    = size_len_reg;
        size_accum_next  = size_accum_reg;
        name_len_next    = name_len_reg;
        data_len_next    = data_len_reg;
        kind             = KIND_NONE;
        ob               = 8'd0;
        status           = ST_START_OK;

        // Field extraction for the byte at this position.
        unique case (phase_reg)
            PH_AWAIT: begin
                if (byte_index_reg == '0) begin
                    size_accum_next = '0;
                    size_len_next   = 8'd0;
                    name_len_next   = 8'd0;
                end else if (idx_w == LEN_W'(2)) begin
                    size_len_next = item.data;
                end else if (idx_w >= LEN_W'(3) && idx_w < l_old_w + LEN_W'(3)) begin
                    size_accum_next = {size_accum_reg[SIZE_W-9:0], item.data};
                end else if (idx_w == l_old_w + LEN_W'(4)) begin
                    name_len_next = item.data;
                end else if (idx_w >= l_old_w + LEN_W'(5) &&
                             idx_w < l_old_w + n_old_w + LEN_W'(5)) begin
                    kind = KIND_NAME;
                    ob   = item.data;
                end
            end
            PH_XFER: begin
                if (idx_w == LEN_W'(2)) begin
                    data_len_next = {item.data, 8'd0};
                end else if (idx_w == LEN_W'(3)) begin
                    data_len_next = {data_len_reg[15:8], item.data};
                end else if (idx_w >= LEN_W'(4) && packet_type_next == TYPE_DATA &&
                             (idx_w - LEN_W'(4)) < LEN_W'(data_len_reg)) begin
                    kind = KIND_PAYLOAD;
                    ob   = item.data;
                end
            end
            PH_DONE, PH_FAIL: begin
                kind = KIND_NONE;
            end
        endcase

        // Packet close checks use the field values after this byte.
        l_new_w  = LEN_W'(size_len_next);
        n_new_w  = LEN_W'(name_len_next);
        d_new_w  = LEN_W'(data_len_next);
        too_long = byte_index_reg >= IDX_W'(MAX_PACKET);

        if (item.last) begin
            if (phase_reg == PH_DONE || phase_reg == PH_FAIL) begin
                status = ST_AFTER_STOP;
            end else if (too_long) begin
                status = ST_IGNORED;
            end else if (phase_reg == PH_AWAIT) begin
                if (len_w < LEN_W'(5) || l_new_w + LEN_W'(4) >= len_w ||
                    l_new_w + n_new_w + LEN_W'(5) > len_w) begin
                    status     = ST_START_REJ;
                    phase_next = PH_FAIL;
                end else begin
                    status     = ST_START_OK;
                    phase_next = PH_XFER;
                end
            end else if (packet_type_next == TYPE_END) begin
                status     = ST_END_SEEN;
                phase_next = PH_DONE;
            end else if (packet_type_next != TYPE_DATA || len_w < LEN_W'(4) ||
                         d_new_w + LEN_W'(4) > len_w) begin
                status = ST_IGNORED;
            end else begin
                status = ST_DATA_OK;
            end
            byte_index_next = '0;
        end else if (byte_index_reg != '1) begin
            byte_index_next = byte_index_reg + IDX_W'(1);
        end else begin
            byte_index_next = byte_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_AWAIT;
            byte_index_reg  <= '0;
            packet_type_reg <= 8'd0;
            size_len_reg    <= 8'd0;
            size_accum_reg  <= '0;
            name_len_reg    <= 8'd0;
            data_len_reg    <= 16'd0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            packet_type_reg <= packet_type_next;
            size_len_reg    <= size_len_next;
            size_accum_reg  <= size_accum_next;
            name_len_reg    <= name_len_next;
            data_len_reg    <= data_len_next;
        end
    end

    always_comb begin
        res.byte_kind     = kind;
        res.out_byte      = ob;
        res.packet_end    = item.last;
        res.packet_status = status;
        res.file_size     = size_accum_next;
        res.name_length   = name_len_next;
        res.phase         = phase_next;
    end

endmodule

// ----- hdl/ftpp_out_reg.sv -----
// ============================================================================
// ftpp_out_reg
// Result register: holds one result word until the sink takes it.
// ============================================================================
module ftpp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    output logic              can_load,
    input  ftpp_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output ftpp_pkg::result_t res_q
);
    import ftpp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && m_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign res_q   = res_reg;

endmodule

// ----- hdl/file_transfer_packet_parser.sv -----
// ============================================================================
// file_transfer_packet_parser
// Receive-side parser for a TLV file-transfer protocol, one packet byte a word.
// ============================================================================
// Path: an accepted word is held in the input register, then its result is
// loaded into the result register and shown on m_* until the sink takes it.
// Throughput: one word per cycle while the sink keeps m_ready high; the parse
// logic is a single pass between the input register and the result register.
// Reset: aresetn is synchronous and active low; it empties both registers and
// returns the parser to awaiting the start packet with all fields cleared.
// ============================================================================
module file_transfer_packet_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // Packet byte channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_last,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_byte_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_packet_end,
    output logic [2:0]  m_packet_status,
    output logic [63:0] m_file_size,
    output logic [7:0]  m_name_length,
    output logic [1:0]  m_phase
);
    import ftpp_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    fire;
    result_t res;
    result_t res_q;

    // The parse stage advances whenever a word is waiting and the result
    // register is either empty or being drained in this same cycle. The
    // ready path is therefore a short chain from m_ready to s_ready.
    assign fire = item_valid && can_load;

    // The input register decouples the upstream handshake from the parse
    // stage, so a new word can be taken while a result still waits.
    ftpp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_last     (s_last),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // The parse stage holds the per-packet state: byte position, packet
    // type, size field length, accumulated size, name length, data length
    // and the transfer phase. It updates only when a word moves on.
    ftpp_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .res     (res)
    );

    // The result register presents one result word per input word.
    ftpp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .can_load (can_load),
        .res      (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_q    (res_q)
    );

    assign m_byte_kind     = res_q.byte_kind;
    assign m_out_byte      = res_q.out_byte;
    assign m_packet_end    = res_q.packet_end;
    assign m_packet_status = res_q.packet_status;
    assign m_file_size     = res_q.file_size;
    assign m_name_length   = res_q.name_length;
    assign m_phase         = res_q.phase;

endmodule

// ----- hdl/ftpp_checker.sv -----
// ============================================================================
// ftpp_checker
// Port-level checks on the result channel of the packet parser.
// ============================================================================
module ftpp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_byte_kind,
    input logic [7:0]  m_out_byte,
    input logic        m_packet_end,
    input logic [2:0]  m_packet_status,
    input logic [63:0] m_file_size,
    input logic [1:0]  m_phase
);
    import ftpp_pkg::*;

    // A stalled result must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
        $stable(m_packet_status) && $stable(m_file_size) && $stable(m_phase))
        else $error("result changed while stalled");

    // Status is only given on the word that closes a packet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_packet_end |-> m_packet_status == ST_START_OK)
        else $error("status given away from packet end");

    // Payload bytes come only while the transfer is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_kind == KIND_PAYLOAD |-> m_phase == PH_XFER)
        else $error("payload byte outside transfer");

    // Name bytes come only from the start packet, never once finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_kind == KIND_NAME |-> m_phase != PH_DONE)
        else $error("name byte after transfer end");

    // An end packet always leaves the transfer finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_end && m_packet_status == ST_END_SEEN |-> m_phase == PH_DONE)
        else $error("end seen without finished phase");

endmodule

bind file_transfer_packet_parser ftpp_checker u_ftpp_checker (.*);

// ----- tb/testbench.sv -----
// ============================================================================
// Testbench for file_transfer_packet_parser
// Feeds whole packets to the parser one word at a time and checks every
// result word against a cycle-free prediction of the receive-side protocol:
// the start packet, data and end packets, short and truncated packets and
// traffic after the transfer has stopped. Both channels idle and stall at
// random.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ftpp_pkg::*;

    // The limit lies well above the length of the slowest correct run.
    localparam int unsigned CYCLE_LIMIT = 100_000;
    // Length of the receiver's long hold-off, long enough to back up the parser.
    localparam int unsigned HOLD_CYCLES = 200;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_last    = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_byte_kind;
    logic [7:0]  m_out_byte;
    logic        m_packet_end;
    logic [2:0]  m_packet_status;
    logic [63:0] m_file_size;
    logic [7:0]  m_name_length;
    logic [1:0]  m_phase;

    file_transfer_packet_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_kind     (m_byte_kind),
        .m_out_byte      (m_out_byte),
        .m_packet_end    (m_packet_end),
        .m_packet_status (m_packet_status),
        .m_file_size     (m_file_size),
        .m_name_length   (m_name_length),
        .m_phase         (m_phase)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shared bookkeeping.
    // ------------------------------------------------------------------------
    item_t       byte_queue[$];     // words waiting to be offered to the parser
    result_t     due_results[$];    // predicted result words, oldest first
    logic [7:0]  pkt[$];            // packet under construction
    int unsigned queued       = 0;  // words handed to the driver so far
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;
    bit          s_took = 1'b0;     // a word was accepted at the last rising edge
    bit          m_took = 1'b0;     // a result was accepted at the last rising edge

    // Our own copy of the parser state, updated once per accepted word.
    phase_t      rx_phase = PH_AWAIT;
    logic [15:0] word_idx = '0;
    logic [7:0]  pkt_type = '0;
    logic [7:0]  size_len = '0;
    logic [63:0] size_acc = '0;
    logic [7:0]  name_len = '0;
    logic [15:0] data_len = '0;

    // ------------------------------------------------------------------------
    // Prediction: works out the result of one accepted word and queues it.
    // ------------------------------------------------------------------------
    function automatic void parse_word(input logic [7:0] b, input logic lst);
        result_t     r;
        int unsigned i;
        int unsigned l;
        int unsigned plen;

        r.byte_kind     = KIND_NONE;
        r.out_byte      = 8'h00;
        r.packet_end    = lst;
        // Zero is what the status shows on a word that does not close a packet.
        r.packet_status = ST_START_OK;
        i    = word_idx;
        l    = size_len;
        plen = i + 1;
        if (i == 0) pkt_type = b;

        if (rx_phase == PH_AWAIT) begin
            // The first packet is taken as a start packet whatever its type byte.
            if (i == 0) begin
                size_acc = '0;
                size_len = '0;
                name_len = '0;
            end else if (i == 2) begin
                size_len = b;
            end else if (i >= 3 && i < 3 + l) begin
                // Big-endian size: older bytes fall off the top beyond 64 bits.
                size_acc = {size_acc[55:0], b};
            end else if (i == 4 + l) begin
                name_len = b;
            end else if (i >= 5 + l && i < 5 + l + name_len) begin
                r.byte_kind = KIND_NAME;
                r.out_byte  = b;
            end
        end else if (rx_phase == PH_XFER) begin
            // The length field is kept whatever the type; payload only for data.
            if (i == 2) begin
                data_len = {b, 8'h00};
            end else if (i == 3) begin
                data_len[7:0] = b;
            end else if (i >= 4 && pkt_type == TYPE_DATA && i - 4 < data_len) begin
                r.byte_kind = KIND_PAYLOAD;
                r.out_byte  = b;
            end
        end

        if (lst) begin
            if (rx_phase == PH_DONE || rx_phase == PH_FAIL) begin
                r.packet_status = ST_AFTER_STOP;
            end else if (i >= MAX_PACKET) begin
                // Treated as a failed link read: no change of phase.
                r.packet_status = ST_IGNORED;
            end else if (rx_phase == PH_AWAIT) begin
                if (plen < 5 || 4 + size_len >= plen || 5 + size_len + name_len > plen) begin
                    r.packet_status = ST_START_REJ;
                    rx_phase        = PH_FAIL;
                end else begin
                    r.packet_status = ST_START_OK;
                    rx_phase        = PH_XFER;
                end
            end else if (pkt_type == TYPE_END) begin
                r.packet_status = ST_END_SEEN;
                rx_phase        = PH_DONE;
            end else if (pkt_type != TYPE_DATA || plen < 4 || 4 + data_len > plen) begin
                r.packet_status = ST_IGNORED;
            end else begin
                r.packet_status = ST_DATA_OK;
            end
            word_idx = '0;
        end else if (word_idx != 16'hFFFF) begin
            // The index saturates on very long packets.
            word_idx = word_idx + 16'd1;
        end

        r.file_size   = size_acc;
        r.name_length = name_len;
        r.phase       = rx_phase;
        due_results.push_back(r);
    endfunction

    function automatic void compare_field(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result %0d, %s: expected %0h, got %0h",
                         results_seen, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Packet construction. Each helper appends to pkt; ship() hands the packet
    // to the driver with the last flag on its final word.
    // ------------------------------------------------------------------------
    function automatic void add_random(input int unsigned n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    // Start packet: random type, random second byte, size-field length, the
    // size bytes, a tag byte, the name length and the name.
    function automatic void build_start(input int unsigned sz, input int unsigned nm);
        add_random(2);
        pkt.push_back(8'(sz));
        add_random(sz + 1);
        pkt.push_back(8'(nm));
        add_random(nm);
    endfunction

    // Data packet: type, sequence byte, declared length, then the given payload.
    function automatic void build_data(input logic [15:0] declared, input int unsigned given);
        pkt.push_back(TYPE_DATA);
        add_random(1);
        pkt.push_back(declared[15:8]);
        pkt.push_back(declared[7:0]);
        add_random(given);
    endfunction

    function automatic void trim(input int unsigned n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endfunction

    function automatic void ship();
        item_t w;
        foreach (pkt[k]) begin
            w.data = pkt[k];
            w.last = (k == pkt.size() - 1);
            byte_queue.push_back(w);
        end
        queued += pkt.size();
        pkt.delete();
    endfunction

    // Waits until every queued word has gone in and every result has come out.
    // Sampled at the rising edge, where the queues can only be seen to shrink.
    task automatic wait_idle();
        do @(posedge aclk);
        while (byte_queue.size() != 0 || s_valid || due_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers one word at a time on the falling edge. A word stays on
    // the port until it is seen accepted; the idle gap before the next word
    // is drawn when a word goes out.
    // ------------------------------------------------------------------------
    int unsigned tx_wait = 0;
    bit          tx_rush = 1'b0;

    always @(negedge aclk) begin : word_driver
        item_t w;
        if (aresetn && !(s_valid && !s_took)) begin
            if (tx_wait != 0) begin
                s_valid <= 1'b0;
                tx_wait--;
            end else if (byte_queue.size() != 0) begin
                w = byte_queue.pop_front();
                s_valid   <= 1'b1;
                s_in_byte <= w.data;
                s_last    <= w.last;
                tx_wait = tx_rush ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 39) == 0) tx_rush = !tx_rush;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: draws a stall before each result, and now and then holds off
    // for a long stretch so that the parser fills and stops taking words.
    // ------------------------------------------------------------------------
    int unsigned rx_wait   = 0;
    bit          rx_rush   = 1'b0;
    int unsigned hold_left = 0;
    int unsigned next_hold = 150;

    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (results_seen >= next_hold) begin
            m_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            next_hold += 5000;
        end else if (m_ready && !m_took) begin
            // Still waiting for the word we said we would take.
        end else if (rx_wait != 0) begin
            m_ready <= 1'b0;
            rx_wait--;
        end else begin
            m_ready <= 1'b1;
            rx_wait = rx_rush ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 39) == 0) rx_rush = !rx_rush;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge. A word going in is
    // predicted before any result is checked, so an expectation is always in
    // place however short the path through the parser.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        result_t want;
        s_took = aresetn && s_valid && s_ready;
        m_took = aresetn && m_valid && m_ready;
        if (s_took) parse_word(s_in_byte, s_last);
        if (m_took) begin
            results_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d arrived with nothing expected", results_seen);
            end else begin
                want = due_results.pop_front();
                compare_field("byte_kind",     want.byte_kind,     m_byte_kind);
                compare_field("out_byte",      want.out_byte,      m_out_byte);
                compare_field("packet_end",    want.packet_end,    m_packet_end);
                compare_field("packet_status", want.packet_status, m_packet_status);
                compare_field("file_size",     want.file_size,     m_file_size);
                compare_field("name_length",   want.name_length,   m_name_length);
                compare_field("phase",         want.phase,         m_phase);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Reset is applied once, so a run follows one transfer from
    // start to finish. Most seeds take the accepted start route through data
    // and end packets; the rest take a rejected start and then see only
    // traffic after the stop.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned goal;
        int unsigned plen;
        int unsigned sz;
        int unsigned nm;
        int unsigned pick;
        logic [7:0]  t;
        bit          reject_route;

        reject_route = ($urandom_range(0, 3) == 0);
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        if (!reject_route) begin
            // Start packet with a nine byte size field, so the top byte drops
            // off, and a name that runs exactly to the end of the packet.
            pkt = '{8'hFF, 8'h00, 8'd9, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE,
                    8'h5A, 8'hA5, 8'h3C, 8'h00, 8'd2, 8'hFF, 8'h00};
            ship();
            // Data packet too short to hold its length field.
            pkt = '{TYPE_DATA, 8'hFF, 8'h80};
            ship();
            // Data packet whose declared length runs past its end.
            pkt = '{TYPE_DATA, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h01};
            ship();
            // Empty payload with a stray trailing word.
            pkt = '{TYPE_DATA, 8'h7F, 8'h00, 8'h00, 8'hEE};
            ship();
            // A one-word packet of an unknown type.
            pkt = '{8'h00};
            ship();
            wait_idle();

            // Random transfer traffic, mostly well-formed data packets.
            goal = queued + 400;
            while (queued < goal) begin
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    plen = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 100)
                                                       : $urandom_range(0, 24);
                    build_data(16'(plen), plen);
                    if ($urandom_range(0, 3) == 0) add_random($urandom_range(1, 3));
                end else if (pick < 15) begin
                    plen = $urandom_range(0, 12);
                    build_data(16'(plen + $urandom_range(1, 400)), plen);
                end else if (pick == 15) begin
                    build_data(16'($urandom), $urandom_range(0, 8));
                end else if (pick == 16) begin
                    // Cut off inside the header.
                    build_data(16'($urandom), 0);
                    trim($urandom_range(1, 3));
                end else begin
                    do t = 8'($urandom);
                    while (t == TYPE_DATA || t == TYPE_END);
                    pkt.push_back(t);
                    add_random($urandom_range(0, 10));
                end
                ship();
            end

            // A single-word end packet stops the transfer.
            pkt = '{TYPE_END};
            ship();
            goal = queued + 60;
        end else begin
            // A start packet that fails one of its length checks.
            case ($urandom_range(0, 2))
                0: add_random($urandom_range(1, 4));
                1: begin
                    sz = $urandom_range(1, 20);
                    build_start(sz, $urandom_range(0, 5));
                    trim($urandom_range(5, 4 + sz));
                end
                default: begin
                    sz = $urandom_range(0, 10);
                    nm = $urandom_range(1, 30);
                    build_start(sz, nm);
                    trim($urandom_range(5 + sz, 4 + sz + nm));
                end
            endcase
            ship();
            wait_idle();
            goal = queued + 460;
        end

        // Everything after the stop is ignored, whatever it looks like.
        while (queued < goal) begin
            add_random($urandom_range(1, 12));
            ship();
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
